### hdl/spi_ncs_pkg.sv
// Package for the SPI NOR command splitter: request modes, opcodes,
// header word type and sizing constants. No dependencies.
package spi_ncs_pkg;

   // Sizing. PAGE_BYTES must be a power of two.
   localparam int PAGE_BYTES   = 256;
   localparam int PAGE_LOG     = $clog2(PAGE_BYTES);
   localparam int MAX_TRANSFER = 4096;
   localparam int MAX_RESULTS  = 17;
   localparam int CNT_W        = $clog2(MAX_RESULTS);
   localparam int LEN_W        = 13;
   localparam int ADDR_W       = 32;
   localparam int MODE_W       = 3;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_READ        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FAST_READ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SECTOR_ERASE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CHIP_ERASE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ_ID     = 3'd5;

   // Flash opcodes
   localparam logic [7:0] OP_READ         = 8'h03;
   localparam logic [7:0] OP_FAST_READ    = 8'h0B;
   localparam logic [7:0] OP_PAGE_PROGRAM = 8'h02;
   localparam logic [7:0] OP_SECTOR_ERASE = 8'h20;
   localparam logic [7:0] OP_CHIP_ERASE   = 8'hC7;
   localparam logic [7:0] OP_READ_ID      = 8'h90;

   // Address byte counts
   localparam logic [2:0] ABYTES_NONE  = 3'd0;
   localparam logic [2:0] ABYTES_THREE = 3'd3;
   localparam logic [2:0] ABYTES_FOUR  = 3'd4;

   localparam logic [ADDR_W-1:0] ADDR_MASK_24 = 32'h00FF_FFFF;

   // One transaction header word
   typedef struct packed {
      logic [7:0]        opcode;
      logic [2:0]        address_bytes;
      logic [ADDR_W-1:0] flash_address;
      logic              dummy_bytes;
      logic [LEN_W-1:0]  data_length;
      logic              data_from_flash;
      logic              enable_write_first;
      logic              wait_busy_after;
      logic              last;
   } hdr_type;

endpackage

### hdl/spi_ncs_if.sv
// Channel interfaces of the SPI NOR command splitter: request, header
// response and configuration write. Depends on spi_ncs_pkg.
interface spi_ncs_req_if;
   logic                             valid;
   logic                             ready;
   logic [spi_ncs_pkg::MODE_W-1:0]   mode;
   logic [spi_ncs_pkg::ADDR_W-1:0]   start_address;
   logic [spi_ncs_pkg::LEN_W-1:0]    byte_count;
   modport source (output valid, mode, start_address, byte_count, input ready);
   modport sink   (input valid, mode, start_address, byte_count, output ready);
endinterface

interface spi_ncs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [7:0]                       opcode;
   logic [2:0]                       address_bytes;
   logic [spi_ncs_pkg::ADDR_W-1:0]   flash_address;
   logic                             dummy_bytes;
   logic [spi_ncs_pkg::LEN_W-1:0]    data_length;
   logic                             data_from_flash;
   logic                             enable_write_first;
   logic                             wait_busy_after;
   logic                             last;
   modport source (output valid, opcode, address_bytes, flash_address, dummy_bytes,
                   data_length, data_from_flash, enable_write_first,
                   wait_busy_after, last, input ready);
   modport sink   (input valid, opcode, address_bytes, flash_address, dummy_bytes,
                   data_length, data_from_flash, enable_write_first,
                   wait_busy_after, last, output ready);
endinterface

interface spi_ncs_csr_if;
   logic valid;
   logic ready;
   logic four_byte_mode;
   modport source (output valid, four_byte_mode, input ready);
   modport sink   (input valid, four_byte_mode, output ready);
endinterface

### hdl/spi_ncs_seq.sv
// Header sequencer: walks one request through its transactions, one
// header per step, with a shared min/subtract unit for the page split.
// Depends on spi_ncs_pkg.
module spi_ncs_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [spi_ncs_pkg::MODE_W-1:0]   mode,
   input  logic [spi_ncs_pkg::ADDR_W-1:0]   start_address,
   input  logic [spi_ncs_pkg::LEN_W-1:0]    byte_count,
   input  logic                             four_byte_mode,
   input  logic                             slot_free,
   output logic                             busy,
   output logic                             emit,
   output spi_ncs_pkg::hdr_type             hdr
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   localparam int LEN_W  = spi_ncs_pkg::LEN_W;
   localparam int ADDR_W = spi_ncs_pkg::ADDR_W;
   localparam int CNT_W  = spi_ncs_pkg::CNT_W;

   state_type                        state_ff;
   logic [spi_ncs_pkg::MODE_W-1:0]   mode_ff;
   logic [ADDR_W-1:0]                addr_ff;
   logic [LEN_W-1:0]                 left_ff;
   logic [LEN_W-1:0]                 room_ff;
   logic [CNT_W-1:0]                 cnt_ff;
   logic [2:0]                       abytes_ff;

   logic [LEN_W-1:0]  count_sat;
   logic [LEN_W-1:0]  room_in;
   logic              has_work;
   logic [LEN_W-1:0]  piece;
   logic [LEN_W-1:0]  left_in;
   logic              final_piece;
   logic [ADDR_W-1:0] addr_in;
   logic [ADDR_W-1:0] addr_sent;

   // Request decode at acceptance
   assign count_sat = (byte_count > LEN_W'(spi_ncs_pkg::MAX_TRANSFER))
                    ? LEN_W'(spi_ncs_pkg::MAX_TRANSFER) : byte_count;
   assign room_in   = LEN_W'(spi_ncs_pkg::PAGE_BYTES)
                    - LEN_W'(start_address[spi_ncs_pkg::PAGE_LOG-1:0]);

   always_comb begin
      priority if (mode == spi_ncs_pkg::MODE_WRITE) begin
         has_work = (count_sat != '0);
      end else if (mode <= spi_ncs_pkg::MODE_READ_ID) begin
         has_work = 1'b1;
      end else begin
         has_work = 1'b0;
      end
   end

   // Shared unit: piece = min(left, room), remainder and next address
   assign piece       = (left_ff < room_ff) ? left_ff : room_ff;
   assign left_in     = left_ff - piece;
   assign addr_in     = addr_ff + ADDR_W'(piece);
   assign final_piece = (left_in == '0)
                     || (cnt_ff == CNT_W'(spi_ncs_pkg::MAX_RESULTS - 1));

   // Address as sent for the stored byte count
   always_comb begin
      unique case (abytes_ff)
         spi_ncs_pkg::ABYTES_FOUR:  addr_sent = addr_ff;
         spi_ncs_pkg::ABYTES_THREE: addr_sent = addr_ff & spi_ncs_pkg::ADDR_MASK_24;
         default:                   addr_sent = '0;
      endcase
   end

   // Header build per mode
   always_comb begin
      hdr                    = '0;
      hdr.address_bytes      = abytes_ff;
      hdr.flash_address      = addr_sent;
      hdr.last               = 1'b1;
      unique case (mode_ff)
         spi_ncs_pkg::MODE_READ: begin
            hdr.opcode          = spi_ncs_pkg::OP_READ;
            hdr.data_length     = left_ff;
            hdr.data_from_flash = 1'b1;
         end
         spi_ncs_pkg::MODE_FAST_READ: begin
            hdr.opcode          = spi_ncs_pkg::OP_FAST_READ;
            hdr.dummy_bytes     = 1'b1;
            hdr.data_length     = left_ff;
            hdr.data_from_flash = 1'b1;
         end
         spi_ncs_pkg::MODE_WRITE: begin
            hdr.opcode             = spi_ncs_pkg::OP_PAGE_PROGRAM;
            hdr.data_length        = piece;
            hdr.enable_write_first = 1'b1;
            hdr.wait_busy_after    = 1'b1;
            hdr.last               = final_piece;
         end
         spi_ncs_pkg::MODE_SECTOR_ERASE: begin
            hdr.opcode             = spi_ncs_pkg::OP_SECTOR_ERASE;
            hdr.enable_write_first = 1'b1;
            hdr.wait_busy_after    = 1'b1;
         end
         spi_ncs_pkg::MODE_CHIP_ERASE: begin
            hdr.opcode             = spi_ncs_pkg::OP_CHIP_ERASE;
            hdr.enable_write_first = 1'b1;
            hdr.wait_busy_after    = 1'b1;
         end
         spi_ncs_pkg::MODE_READ_ID: begin
            hdr.opcode          = spi_ncs_pkg::OP_READ_ID;
            hdr.data_length     = LEN_W'(2);
            hdr.data_from_flash = 1'b1;
         end
         default: begin
            hdr.last = 1'b1;
         end
      endcase
   end

   assign busy = (state_ff == ST_EMIT);
   assign emit = busy && slot_free;

   // Sequencer state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start && has_work) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit && hdr.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end

      if (state_ff == ST_IDLE && start) begin
         mode_ff <= mode;
         left_ff <= count_sat;
         room_ff <= room_in;
         cnt_ff  <= '0;
         priority if (mode == spi_ncs_pkg::MODE_CHIP_ERASE) begin
            abytes_ff <= spi_ncs_pkg::ABYTES_NONE;
            addr_ff   <= '0;
         end else if (mode == spi_ncs_pkg::MODE_READ_ID) begin
            abytes_ff <= spi_ncs_pkg::ABYTES_THREE;
            addr_ff   <= '0;
         end else begin
            abytes_ff <= four_byte_mode ? spi_ncs_pkg::ABYTES_FOUR
                                        : spi_ncs_pkg::ABYTES_THREE;
            addr_ff   <= start_address;
         end
      end else if (emit) begin
         addr_ff <= addr_in;
         left_ff <= left_in;
         room_ff <= LEN_W'(spi_ncs_pkg::PAGE_BYTES);
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
   end

endmodule

### hdl/spi_nor_command_splitter.sv
// Top level of the SPI NOR command splitter: channel handshakes, the
// four-byte mode register and the header output register.
// Depends on spi_ncs_pkg, spi_ncs_if and spi_ncs_seq.
//
// Usage: a request word (mode, start_address, byte_count) enters on req_ch;
// the transaction headers that carry it out leave on rsp_ch, one word per
// header, the final one flagged with last. csr_ch writes four_byte_mode and
// is always ready; write it only while no request is in flight.
// Flow: an accepted request moves the sequencer into its emit state, and
// each header it emits enters the output register and so reaches rsp_ch.
// Following headers come one per cycle while rsp_ch is ready; a request
// yields up to 17 headers (a page-split write of 4096 bytes). req_ch.ready
// is low from acceptance until the last header is in the output register;
// the sequencer's one min/subtract unit yields one header per step.
// Empty writes and unknown modes are accepted and produce nothing.
// A stall on rsp_ch holds the current header in the output register and
// freezes the sequencer; nothing is lost. Synchronous reset clears the
// sequencer, the output valid and four_byte_mode (three-byte addressing).
module spi_nor_command_splitter (
   input  logic                 clock,
   input  logic                 reset,
   spi_ncs_req_if.sink          req_ch,
   spi_ncs_rsp_if.source        rsp_ch,
   spi_ncs_csr_if.sink          csr_ch
);

   logic                  four_byte_ff;
   logic                  rsp_valid_ff;
   spi_ncs_pkg::hdr_type  rsp_hdr_ff;

   logic                  busy;
   logic                  emit;
   logic                  slot_free;
   logic                  req_take;
   spi_ncs_pkg::hdr_type  hdr;

   // Handshakes
   assign req_ch.ready = !busy;
   assign req_take     = req_ch.valid && !busy;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   spi_ncs_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (req_take),
      .mode           (req_ch.mode),
      .start_address  (req_ch.start_address),
      .byte_count     (req_ch.byte_count),
      .four_byte_mode (four_byte_ff),
      .slot_free      (slot_free),
      .busy           (busy),
      .emit           (emit),
      .hdr            (hdr)
   );

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         four_byte_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         four_byte_ff <= csr_ch.four_byte_mode;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_hdr_ff <= hdr;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.opcode             = rsp_hdr_ff.opcode;
   assign rsp_ch.address_bytes      = rsp_hdr_ff.address_bytes;
   assign rsp_ch.flash_address      = rsp_hdr_ff.flash_address;
   assign rsp_ch.dummy_bytes        = rsp_hdr_ff.dummy_bytes;
   assign rsp_ch.data_length        = rsp_hdr_ff.data_length;
   assign rsp_ch.data_from_flash    = rsp_hdr_ff.data_from_flash;
   assign rsp_ch.enable_write_first = rsp_hdr_ff.enable_write_first;
   assign rsp_ch.wait_busy_after    = rsp_hdr_ff.wait_busy_after;
   assign rsp_ch.last               = rsp_hdr_ff.last;

endmodule
